### src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the rotation matrix to quaternion block
// This package holds the Q2.30 constants, the square root pipeline depth and
// the format of the classified item that passes from the front to the back.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned EPS_W     = 31;
  localparam int unsigned RAD_W     = 33;   // clamped radicand, below 7 * 2^30
  localparam int unsigned WIDE_W    = 35;   // signed radicand and its inputs
  localparam int unsigned ROOT_W    = 31;   // square root result bits
  localparam int unsigned NUM_STG   = ROOT_W;
  localparam int unsigned SRC_W     = 2 * ROOT_W;  // radicand scaled by 2^28
  localparam int unsigned REM_W     = 35;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_AW      = $clog2(Q_DEPTH);

  localparam logic [WIDE_W-1:0] Q30_ONE   = WIDE_W'(64'd1 << 30);
  localparam logic [EPS_W-1:0]  EPS_RESET = EPS_W'(1074);

  // Lane order inside the item: w, x, y, z.
  localparam int unsigned LANE_W = 0;
  localparam int unsigned LANES  = 4;

  typedef struct packed {
    logic [LANES-1:0][RAD_W-1:0] rad;   // clamped; vector lanes already zero when below epsilon
    logic [LANES-1:0]            neg;   // w lane is never negative
  } rad_item_t;

endpackage

### src/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front: radicand formation and classification
// Forms the four radicands of an incoming matrix, clamps negative ones,
// applies the epsilon test and the sign rule, and holds the epsilon register.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rmq_pkg::EPS_W-1:0]      cfg_data,
  input  logic signed [rmq_pkg::FIELD_W-1:0] r00,
  input  logic signed [rmq_pkg::FIELD_W-1:0] r01,
  input  logic signed [rmq_pkg::FIELD_W-1:0] r02,
  input  logic signed [rmq_pkg::FIELD_W-1:0] r10,
  input  logic signed [rmq_pkg::FIELD_W-1:0] r11,
  input  logic signed [rmq_pkg::FIELD_W-1:0] r12,
  input  logic signed [rmq_pkg::FIELD_W-1:0] r20,
  input  logic signed [rmq_pkg::FIELD_W-1:0] r21,
  input  logic signed [rmq_pkg::FIELD_W-1:0] r22,
  output rmq_pkg::rad_item_t             item
);

  logic [rmq_pkg::EPS_W-1:0] eps_r;
  logic [rmq_pkg::EPS_W-1:0] eps_nxt;

  assign cfg_ready = 1'b1;
  assign eps_nxt   = (cfg_valid && cfg_ready) ? cfg_data : eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= rmq_pkg::EPS_RESET;
    end else begin
      eps_r <= eps_nxt;
    end
  end

  logic signed [rmq_pkg::WIDE_W-1:0] a00, a11, a22;
  logic signed [rmq_pkg::WIDE_W-1:0] rad [rmq_pkg::LANES];
  logic signed [rmq_pkg::WIDE_W-1:0] dif [rmq_pkg::LANES];
  logic        [rmq_pkg::WIDE_W-1:0] mag [rmq_pkg::LANES];

  assign a00 = rmq_pkg::WIDE_W'(r00);
  assign a11 = rmq_pkg::WIDE_W'(r11);
  assign a22 = rmq_pkg::WIDE_W'(r22);

  always_comb begin
    rad[0] = a00 + a11 + a22 + $signed(rmq_pkg::Q30_ONE);
    rad[1] = a00 - a11 - a22 + $signed(rmq_pkg::Q30_ONE);
    rad[2] = a11 - a22 - a00 + $signed(rmq_pkg::Q30_ONE);
    rad[3] = a22 - a00 - a11 + $signed(rmq_pkg::Q30_ONE);
    dif[0] = '0;
    dif[1] = rmq_pkg::WIDE_W'(r21) - rmq_pkg::WIDE_W'(r12);
    dif[2] = rmq_pkg::WIDE_W'(r02) - rmq_pkg::WIDE_W'(r20);
    dif[3] = rmq_pkg::WIDE_W'(r10) - rmq_pkg::WIDE_W'(r01);
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      mag[l] = rad[l][rmq_pkg::WIDE_W-1] ? rmq_pkg::WIDE_W'(-rad[l])
                                         : rmq_pkg::WIDE_W'(rad[l]);
      if (rad[l][rmq_pkg::WIDE_W-1]) begin
        item.rad[l] = '0;
      end else begin
        item.rad[l] = rad[l][rmq_pkg::RAD_W-1:0];
      end
      item.neg[l] = dif[l][rmq_pkg::WIDE_W-1];
      // A vector component whose radicand is small in magnitude is exactly zero.
      if (l != rmq_pkg::LANE_W &&
          mag[l] < {{(rmq_pkg::WIDE_W-rmq_pkg::EPS_W){1'b0}}, eps_r}) begin
        item.rad[l] = '0;
        item.neg[l] = 1'b0;
      end
    end
  end

endmodule

### src/rmq_queue.sv
// ----------------------------------------------------------------------------
// rmq_queue: short queue between the front and the square root pipeline
// A small first-in first-out buffer of classified items with full and empty.
// ----------------------------------------------------------------------------
module rmq_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rmq_pkg::rad_item_t wdata,
  output logic               full,
  input  logic               pop,
  output rmq_pkg::rad_item_t rdata,
  output logic               empty
);

  rmq_pkg::rad_item_t mem [rmq_pkg::Q_DEPTH];

  logic [rmq_pkg::Q_AW-1:0] wptr_r, wptr_nxt;
  logic [rmq_pkg::Q_AW-1:0] rptr_r, rptr_nxt;
  logic [rmq_pkg::Q_AW:0]   cnt_r, cnt_nxt;
  logic                     do_push, do_pop;

  assign full    = (cnt_r == (rmq_pkg::Q_AW+1)'(rmq_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (rmq_pkg::Q_AW+1)'(do_push) - (rmq_pkg::Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (rmq_pkg::Q_AW+1)'(rmq_pkg::Q_DEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != (rmq_pkg::Q_AW+1)'(rmq_pkg::Q_DEPTH)) |->
      (wptr_r - rptr_r) == cnt_r[rmq_pkg::Q_AW-1:0])
    else $error("queue pointers disagree with count");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

### src/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back: pipelined square roots and sign application
// Four lanes of a digit-by-digit square root, one result bit per stage,
// followed by negation of the vector parts that carry a negative sign.
// ----------------------------------------------------------------------------
module rmq_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rmq_pkg::rad_item_t                  head,
  input  logic                                head_valid,
  output logic                                head_pop,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [rmq_pkg::FIELD_W-1:0]  quat_w,
  output logic signed [rmq_pkg::FIELD_W-1:0]  quat_x,
  output logic signed [rmq_pkg::FIELD_W-1:0]  quat_y,
  output logic signed [rmq_pkg::FIELD_W-1:0]  quat_z
);

  localparam int unsigned NS = rmq_pkg::NUM_STG;
  localparam int unsigned NL = rmq_pkg::LANES;

  logic                                   vld_r [NS];
  logic [NL-1:0]                          neg_r [NS];
  logic [NL-1:0][rmq_pkg::REM_W-1:0]      rem_r [NS];
  logic [NL-1:0][rmq_pkg::ROOT_W-1:0]     res_r [NS];
  logic [NL-1:0][rmq_pkg::SRC_W-1:0]      src_r [NS];

  logic                                   vld_nxt [NS];
  logic [NL-1:0]                          neg_nxt [NS];
  logic [NL-1:0][rmq_pkg::REM_W-1:0]      rem_nxt [NS];
  logic [NL-1:0][rmq_pkg::ROOT_W-1:0]     res_nxt [NS];
  logic [NL-1:0][rmq_pkg::SRC_W-1:0]      src_nxt [NS];

  logic adv;

  // The whole pipeline moves together; it holds only while a result waits.
  assign adv      = !vld_r[NS-1] || out_pop;
  assign head_pop = adv && head_valid;

  for (genvar s = 0; s < NS; s++) begin : g_stg
    logic                               p_vld;
    logic [NL-1:0]                      p_neg;
    logic [NL-1:0][rmq_pkg::REM_W-1:0]  p_rem;
    logic [NL-1:0][rmq_pkg::ROOT_W-1:0] p_res;
    logic [NL-1:0][rmq_pkg::SRC_W-1:0]  p_src;

    if (s == 0) begin : g_first
      always_comb begin
        p_vld = head_valid;
        p_neg = head.neg;
        for (int l = 0; l < NL; l++) begin
          p_rem[l] = '0;
          p_res[l] = '0;
          // Radicand times 2^28 sits in the top of the source word.
          p_src[l] = {1'b0, head.rad[l], 28'd0};
        end
      end
    end else begin : g_rest
      always_comb begin
        p_vld = vld_r[s-1];
        p_neg = neg_r[s-1];
        p_rem = rem_r[s-1];
        p_res = res_r[s-1];
        p_src = src_r[s-1];
      end
    end

    always_comb begin
      logic [rmq_pkg::REM_W-1:0] part;
      logic [rmq_pkg::REM_W-1:0] trial;
      vld_nxt[s] = p_vld;
      neg_nxt[s] = p_neg;
      for (int l = 0; l < NL; l++) begin
        part  = {p_rem[l][rmq_pkg::REM_W-3:0],
                 p_src[l][rmq_pkg::SRC_W-1 -: 2]};
        trial = {{(rmq_pkg::REM_W-rmq_pkg::ROOT_W-2){1'b0}}, p_res[l], 2'b01};
        if (part >= trial) begin
          rem_nxt[s][l] = part - trial;
          res_nxt[s][l] = {p_res[l][rmq_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = part;
          res_nxt[s][l] = {p_res[l][rmq_pkg::ROOT_W-2:0], 1'b0};
        end
        src_nxt[s][l] = {p_src[l][rmq_pkg::SRC_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_nxt[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        neg_r[s] <= neg_nxt[s];
        rem_r[s] <= rem_nxt[s];
        res_r[s] <= res_nxt[s];
        src_r[s] <= src_nxt[s];
      end
    end
  end

  logic [rmq_pkg::FIELD_W-1:0] mag [NL];
  logic [rmq_pkg::FIELD_W-1:0] fld [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      mag[l] = {1'b0, res_r[NS-1][l]};
      fld[l] = neg_r[NS-1][l] ? (~mag[l] + 1'b1) : mag[l];
    end
  end

  assign out_empty = !vld_r[NS-1];
  assign quat_w    = fld[0];
  assign quat_x    = fld[1];
  assign quat_y    = fld[2];
  assign quat_z    = fld[3];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NS-1] && !out_pop) |=> (vld_r[NS-1] && $stable(res_r[NS-1])))
    else $error("waiting result changed before it was taken");

  a_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] |-> !neg_r[NS-1][rmq_pkg::LANE_W])
    else $error("scalar part marked negative");

  a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> !head_pop)
    else $error("queue popped while pipeline stalled");

endmodule

### src/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: rotation matrix to unit quaternion, Q2.30
// Converts a 3x3 rotation matrix to the quaternion (w, x, y, z).
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes the nine matrix elements; a transaction happens at
// a clock edge with in_push high and in_full low. The result channel shows the
// oldest quaternion while out_empty is low and hands it over at an edge with
// out_pop high. The epsilon register is written through cfg_valid/cfg_ready
// and cfg_data; write it only while no transaction is in flight.
// Throughput is one matrix per cycle while out_pop keeps the pipeline moving.
// A matrix accepted at one edge lands in a 4-entry queue, then passes a
// 31-stage square root pipeline that produces one root bit per stage in each
// of four lanes before its result appears on the output.
// When out_pop stays low the pipeline holds in place, the queue fills and
// in_full rises; no transaction is lost. Reset empties the queue and the
// pipeline and sets epsilon to 1074.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [rmq_pkg::FIELD_W-1:0]  in_r00,
  input  logic signed [rmq_pkg::FIELD_W-1:0]  in_r01,
  input  logic signed [rmq_pkg::FIELD_W-1:0]  in_r02,
  input  logic signed [rmq_pkg::FIELD_W-1:0]  in_r10,
  input  logic signed [rmq_pkg::FIELD_W-1:0]  in_r11,
  input  logic signed [rmq_pkg::FIELD_W-1:0]  in_r12,
  input  logic signed [rmq_pkg::FIELD_W-1:0]  in_r20,
  input  logic signed [rmq_pkg::FIELD_W-1:0]  in_r21,
  input  logic signed [rmq_pkg::FIELD_W-1:0]  in_r22,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [rmq_pkg::FIELD_W-1:0]  out_quat_w,
  output logic signed [rmq_pkg::FIELD_W-1:0]  out_quat_x,
  output logic signed [rmq_pkg::FIELD_W-1:0]  out_quat_y,
  output logic signed [rmq_pkg::FIELD_W-1:0]  out_quat_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rmq_pkg::EPS_W-1:0]           cfg_data
);

  rmq_pkg::rad_item_t front_item;
  rmq_pkg::rad_item_t q_head;
  logic               q_empty;
  logic               q_pop;

  rmq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .r00       (in_r00),
    .r01       (in_r01),
    .r02       (in_r02),
    .r10       (in_r10),
    .r11       (in_r11),
    .r12       (in_r12),
    .r20       (in_r20),
    .r21       (in_r21),
    .r22       (in_r22),
    .item      (front_item)
  );

  rmq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_item),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  rmq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_empty),
    .head_pop   (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .quat_w     (out_quat_w),
    .quat_x     (out_quat_x),
    .quat_y     (out_quat_y),
    .quat_z     (out_quat_z)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the rotation matrix to quaternion converter
// Matrices go in through the push/full port and quaternions come back through
// the empty/pop port. Each result is checked field by field against an
// in-bench model of the Q2.30 conversion. The epsilon register is swept
// across several settings, including its extremes, between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DRAIN_CYCLES = 40;  // pipeline is 31 deep plus queue

  typedef logic signed [rmq_pkg::FIELD_W-1:0] elem_t;
  typedef elem_t matrix_t [9];
  typedef struct {
    elem_t w;
    elem_t x;
    elem_t y;
    elem_t z;
  } quat_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  elem_t in_r00, in_r01, in_r02, in_r10, in_r11, in_r12, in_r20, in_r21, in_r22;
  logic out_empty;
  logic out_pop;
  elem_t out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [rmq_pkg::EPS_W-1:0] cfg_data;

  logic [rmq_pkg::EPS_W-1:0] model_epsilon;
  quat_t quat_expected [$];
  int unsigned mismatches;
  int unsigned hold_cycles;
  int unsigned pop_stall;
  bit no_idle;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_r00(in_r00), .in_r01(in_r01), .in_r02(in_r02),
    .in_r10(in_r10), .in_r11(in_r11), .in_r12(in_r12),
    .in_r20(in_r20), .in_r21(in_r21), .in_r22(in_r22),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Integer square root, one result bit per pass.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned rest;
    longint unsigned root;
    longint unsigned probe;
    rest = v;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Half the square root of a Q2.30 radicand; negative radicands give zero.
  function automatic longint unsigned half_sqrt_q30(input longint signed rad);
    if (rad <= 0) return 0;
    return int_sqrt(longint'(rad) << 28);
  endfunction

  function automatic elem_t vector_part(input longint signed rad,
                                        input longint signed diff);
    longint unsigned mag;
    if ((rad < 0 ? -rad : rad) < longint'(model_epsilon)) return '0;
    mag = half_sqrt_q30(rad);
    return (diff < 0) ? elem_t'(-mag) : elem_t'(mag);
  endfunction

  function automatic quat_t matrix_to_quat(input matrix_t m);
    longint signed a [9];
    longint signed one;
    quat_t q;
    one = longint'(1) << 30;
    for (int i = 0; i < 9; i++) a[i] = m[i];
    q.w = elem_t'(half_sqrt_q30(a[0] + a[4] + a[8] + one));
    q.x = vector_part(a[0] - a[4] - a[8] + one, a[7] - a[5]);
    q.y = vector_part(a[4] - a[8] - a[0] + one, a[2] - a[6]);
    q.z = vector_part(a[8] - a[0] - a[4] + one, a[3] - a[1]);
    return q;
  endfunction

  task automatic report_mismatch(input string what, input elem_t got, input elem_t want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Result side: pops with random stalls, or holds off for a long stretch.
  always @(posedge clk) begin
    quat_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (quat_expected.size() == 0) begin
          report_mismatch("unexpected quat_w", out_quat_w, '0);
        end else begin
          want = quat_expected.pop_front();
          if (out_quat_w !== want.w) report_mismatch("quat_w", out_quat_w, want.w);
          if (out_quat_x !== want.x) report_mismatch("quat_x", out_quat_x, want.x);
          if (out_quat_y !== want.y) report_mismatch("quat_y", out_quat_y, want.y);
          if (out_quat_z !== want.z) report_mismatch("quat_z", out_quat_z, want.z);
        end
        pop_stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop <= 1'b0;
      end else if (pop_stall > 0) begin
        pop_stall--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Sends one matrix; in_push is left high so back-to-back items need no gap.
  task automatic send_matrix(input matrix_t m);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_r00 <= m[0]; in_r01 <= m[1]; in_r02 <= m[2];
    in_r10 <= m[3]; in_r11 <= m[4]; in_r12 <= m[5];
    in_r20 <= m[6]; in_r21 <= m[7]; in_r22 <= m[8];
    do @(posedge clk); while (in_full);
    quat_expected.push_back(matrix_to_quat(m));
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [rmq_pkg::EPS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_epsilon = value;
  endtask

  function automatic elem_t to_q30(input real v);
    return elem_t'($rtoi(v * 1073741824.0 + (v < 0.0 ? -0.5 : 0.5)));
  endfunction

  function automatic real rand_unit();
    return ($itor($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
  endfunction

  // A rotation built from a random unit quaternion, sometimes axis aligned,
  // and at times with a little noise in the low bits.
  function automatic matrix_t random_rotation();
    real qw, qx, qy, qz, n;
    matrix_t m;
    do begin
      qw = rand_unit(); qx = rand_unit(); qy = rand_unit(); qz = rand_unit();
      if ($urandom_range(0, 3) == 0) qx = 0.0;
      if ($urandom_range(0, 3) == 0) qy = 0.0;
      if ($urandom_range(0, 3) == 0) qz = 0.0;
      if ($urandom_range(0, 5) == 0) qw = 0.0;
      n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    end while (n < 0.01);
    qw /= n; qx /= n; qy /= n; qz /= n;
    m[0] = to_q30(1.0 - 2.0 * (qy * qy + qz * qz));
    m[1] = to_q30(2.0 * (qx * qy - qz * qw));
    m[2] = to_q30(2.0 * (qx * qz + qy * qw));
    m[3] = to_q30(2.0 * (qx * qy + qz * qw));
    m[4] = to_q30(1.0 - 2.0 * (qx * qx + qz * qz));
    m[5] = to_q30(2.0 * (qy * qz - qx * qw));
    m[6] = to_q30(2.0 * (qx * qz - qy * qw));
    m[7] = to_q30(2.0 * (qy * qz + qx * qw));
    m[8] = to_q30(1.0 - 2.0 * (qx * qx + qy * qy));
    if ($urandom_range(0, 1) == 1)
      for (int i = 0; i < 9; i++) m[i] = m[i] + elem_t'($urandom_range(0, 2048)) - 1024;
    return m;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return random_rotation();
    for (int i = 0; i < 9; i++)
      m[i] = (pick < 17) ? elem_t'($urandom_range(0, 32'h8000_0000)) - elem_t'(32'h4000_0000)
                         : elem_t'($urandom());
    return m;
  endfunction

  function automatic matrix_t diag(input elem_t a, input elem_t b, input elem_t c);
    matrix_t m;
    for (int i = 0; i < 9; i++) m[i] = '0;
    m[0] = a; m[4] = b; m[8] = c;
    return m;
  endfunction

  task automatic test_directed();
    matrix_t m;
    elem_t one;
    elem_t minv;
    elem_t maxv;
    one = elem_t'(32'h4000_0000);
    minv = elem_t'(32'h8000_0000);
    maxv = elem_t'(32'h7fff_ffff);
    send_matrix(diag(one, one, one));        // identity
    send_matrix(diag(one, -one, -one));      // half turn about each axis
    send_matrix(diag(-one, one, -one));
    send_matrix(diag(-one, -one, one));
    send_matrix(diag(-one, -one, -one));     // only the w radicand negative
    send_matrix(diag(minv, minv, minv));
    send_matrix(diag(maxv, maxv, maxv));
    send_matrix(diag(maxv, minv, minv));     // largest x magnitude
    // Epsilon, one below it and their negatives on the first diagonal element.
    send_matrix(diag(elem_t'(model_epsilon), one, one));
    send_matrix(diag(elem_t'(model_epsilon) - 1, one, one));
    send_matrix(diag(-elem_t'(model_epsilon), one, one));
    send_matrix(diag(-elem_t'(model_epsilon) + 1, one, one));
    // Off-diagonal differences: zero, positive and negative.
    m = diag(0, 0, 0);
    m[7] = 100; m[5] = 100; m[2] = -5; m[6] = 5; m[3] = 7; m[1] = -7;
    send_matrix(m);
    m[7] = -1; m[5] = 0; m[2] = 3; m[6] = 2; m[3] = minv; m[1] = maxv;
    send_matrix(m);
    m[7] = maxv; m[5] = minv; m[2] = minv; m[6] = maxv; m[3] = 0; m[1] = 1;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = maxv;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = minv;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = elem_t'(32'h5555_5555 << (i % 2));
    send_matrix(m);
    wait_idle();
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_matrix(random_matrix());
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // Receiver holds off so the block fills up and raises in_full.
  task automatic test_backpressure();
    hold_cycles = 150;
    no_idle = 1'b1;
    for (int i = 0; i < 60; i++) send_matrix(random_matrix());
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_epsilon_sweep();
    write_epsilon(rmq_pkg::EPS_W'(0));
    test_directed();
    test_random(150);
    write_epsilon(rmq_pkg::EPS_W'(32'h7fff_ffff));
    test_directed();
    test_random(100);
    write_epsilon(rmq_pkg::EPS_W'(32'h4000_0000));
    test_random(100);
    write_epsilon(rmq_pkg::EPS_W'($urandom_range(0, 1 << 20)));
    test_directed();
    test_random(100);
    write_epsilon(rmq_pkg::EPS_RESET);
    test_random(100);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    {in_r00, in_r01, in_r02, in_r10, in_r11, in_r12, in_r20, in_r21, in_r22} = '0;
    model_epsilon = rmq_pkg::EPS_RESET;
    mismatches = 0;
    hold_cycles = 0;
    pop_stall = 0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(170);
    test_backpressure();
    test_epsilon_sweep();

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### rotation_matrix_to_quaternion.f
src/rmq_pkg.sv
src/rmq_front.sv
src/rmq_queue.sv
src/rmq_back.sv
src/rotation_matrix_to_quaternion.sv
verif/tb_top.sv
